/* hdl/bsfd_pkg.sv */
// ---------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants of the bit-stuffed frame deframer with CRC-8.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsfd_pkg;

    // line framing
    localparam int FLAG_BITS   = 8;
    localparam int HEADER_BITS = 16;
    localparam int CRC_BITS    = 8;
    localparam int ONES_LIMIT  = 5;

    // crc-8 polynomial x^8+x^2+x+1, low byte
    localparam logic [7:0] CRC_POLY_LOW = 8'h07;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_ADDRESS      = 2'd0;
    localparam logic [1:0] REG_PEER_ADDRESS     = 2'd1;
    localparam logic [1:0] REG_PEER_ADDRESS_SET = 2'd2;

    // frame type codes
    localparam logic [1:0] TYPE_I     = 2'd0;
    localparam logic [1:0] TYPE_S     = 2'd1;
    localparam logic [1:0] TYPE_OTHER = 2'd2;

    // configuration seen by the back part
    typedef struct packed {
        logic [3:0] own_address;
        logic [3:0] peer_address;
        logic       peer_address_set;
    } cfg_t;

    // per item event passed from front to back
    typedef struct packed {
        logic field_valid;   // a destuffed bit has left the crc delay line
        logic field_bit;
        logic eof;
        logic crc_zero;      // crc register after this item is zero
        logic crc_full;      // crc delay line has been filled
    } event_t;

    // one result item
    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic       crc_ok;
        logic       address_ok;
        logic       frame_ok;
        logic [1:0] frame_type;
        logic [2:0] frame_number;
        logic       last_frame;
        logic       too_short;
    } result_t;

endpackage

/* hdl/bsfd_front.sv */
// ---------------------------------------------------------------------------
// bsfd_front
// Flag removal, bit destuffing and crc-8 division, one line bit per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               rx_bit,
    input  logic               end_of_frame,
    input  logic               queue_full,
    output logic               push,
    output bsfd_pkg::event_t   push_event
);
    import bsfd_pkg::*;

    logic [3:0] flag_skip_reg, flag_skip_next;
    logic [7:0] raw_line_reg, raw_line_next;
    logic [3:0] raw_fill_reg, raw_fill_next;
    logic [2:0] ones_reg, ones_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] crc_line_reg, crc_line_next;
    logic [3:0] crc_fill_reg, crc_fill_next;
    logic       body_valid;
    logic       body_bit;
    logic       take;

    // handshake
    assign take     = in_valid && !queue_full;
    assign in_stall = queue_full;
    assign push     = take;

    // next state of the bit pipeline for the offered item
    always_comb
    begin
        flag_skip_next = flag_skip_reg;
        raw_line_next  = raw_line_reg;
        raw_fill_next  = raw_fill_reg;
        ones_next      = ones_reg;
        crc_next       = crc_reg;
        crc_line_next  = crc_line_reg;
        crc_fill_next  = crc_fill_reg;
        body_valid     = 1'b0;
        body_bit       = raw_line_reg[7];
        push_event     = '0;

        // opening flag, then the raw delay line that hides the closing flag
        if (flag_skip_reg < 4'(FLAG_BITS))
        begin
            flag_skip_next = flag_skip_reg + 4'd1;
        end
        else
        begin
            if (raw_fill_reg >= 4'(FLAG_BITS))
                body_valid = 1'b1;
            else
                raw_fill_next = raw_fill_reg + 4'd1;
            raw_line_next = {raw_line_reg[6:0], rx_bit};
        end

        // destuffing and crc division
        if (body_valid)
        begin
            if (ones_reg >= 3'(ONES_LIMIT) && !body_bit)
            begin
                ones_next = 3'd0;
            end
            else
            begin
                if (body_bit)
                begin
                    if (ones_reg < 3'(ONES_LIMIT))
                        ones_next = ones_reg + 3'd1;
                end
                else
                begin
                    ones_next = 3'd0;
                end
                crc_next = {crc_reg[6:0], body_bit} ^ (crc_reg[7] ? CRC_POLY_LOW : 8'h00);
                if (crc_fill_reg >= 4'(CRC_BITS))
                begin
                    push_event.field_valid = 1'b1;
                    push_event.field_bit   = crc_line_reg[7];
                end
                else
                begin
                    crc_fill_next = crc_fill_reg + 4'd1;
                end
                crc_line_next = {crc_line_reg[6:0], body_bit};
            end
        end

        push_event.eof      = end_of_frame;
        push_event.crc_zero = (crc_next == 8'h00);
        push_event.crc_full = (crc_fill_next >= 4'(CRC_BITS));

        // frame end clears everything for the next frame
        if (end_of_frame)
        begin
            flag_skip_next = '0;
            raw_line_next  = '0;
            raw_fill_next  = '0;
            ones_next      = '0;
            crc_next       = '0;
            crc_line_next  = '0;
            crc_fill_next  = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_skip_reg <= '0;
            raw_line_reg  <= '0;
            raw_fill_reg  <= '0;
            ones_reg      <= '0;
            crc_reg       <= '0;
            crc_line_reg  <= '0;
            crc_fill_reg  <= '0;
        end
        else if (take)
        begin
            flag_skip_reg <= flag_skip_next;
            raw_line_reg  <= raw_line_next;
            raw_fill_reg  <= raw_fill_next;
            ones_reg      <= ones_next;
            crc_reg       <= crc_next;
            crc_line_reg  <= crc_line_next;
            crc_fill_reg  <= crc_fill_next;
        end
    end

endmodule

/* hdl/bsfd_queue.sv */
// ---------------------------------------------------------------------------
// bsfd_queue
// Short first-in first-out queue of events between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfd_queue #(
    parameter int DEPTH = bsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bsfd_pkg::event_t   push_event,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output bsfd_pkg::event_t   head_event
);
    import bsfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    event_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_event = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_event;
    end

endmodule

/* hdl/bsfd_back.sv */
// ---------------------------------------------------------------------------
// bsfd_back
// Header capture, byte assembly, frame status and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bsfd_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  bsfd_pkg::event_t   head_event,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output bsfd_pkg::result_t  out_result
);
    import bsfd_pkg::*;

    logic [4:0]  pos_reg, pos_next;
    logic [15:0] header_reg, header_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        held_valid_reg, held_valid_next;
    result_t     held_reg, held_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        out_free;
    logic        made;
    logic        have_result;
    result_t     result_now;
    result_t     status;
    logic        short_frame;
    logic [7:0]  ctl;

    assign out_free   = !out_valid_reg || !out_stall;
    assign pop        = head_valid && out_free;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // field bits: header first, then payload bytes of i-frames
    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        byte_next   = byte_reg;
        cnt_next    = cnt_reg;
        made        = 1'b0;
        if (head_event.field_valid)
        begin
            if (pos_reg < 5'(HEADER_BITS))
            begin
                header_next = {header_reg[14:0], head_event.field_bit};
                pos_next    = pos_reg + 5'd1;
            end
            else if (!header_reg[7])
            begin
                byte_next = {byte_reg[6:0], head_event.field_bit};
                if (cnt_reg == 3'd7)
                begin
                    made     = 1'b1;
                    cnt_next = 3'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
        end
    end

    // frame status from the state after this item
    always_comb
    begin
        ctl          = header_next[7:0];
        short_frame  = !(pos_next >= 5'(HEADER_BITS) && head_event.crc_full);
        status       = '0;
        status.is_status  = 1'b1;
        status.crc_ok     = head_event.crc_zero;
        status.frame_type = TYPE_OTHER;
        status.too_short  = short_frame;
        if (!short_frame)
        begin
            status.address_ok = (header_next[15:12] == cfg.own_address) &&
                                (!cfg.peer_address_set ||
                                 header_next[11:8] == cfg.peer_address);
            if (!ctl[7])
            begin
                status.frame_type   = TYPE_I;
                status.frame_number = ctl[6:4];
                status.last_frame   = ctl[3];
            end
            else if (!ctl[6])
            begin
                status.frame_type   = TYPE_S;
                status.frame_number = ctl[2:0];
                status.last_frame   = ctl[3];
            end
        end
        status.frame_ok = status.crc_ok && status.address_ok && !short_frame;
    end

    // result choice: payload byte, held status, or this frame's status
    always_comb
    begin
        held_next       = held_reg;
        held_valid_next = 1'b0;
        have_result     = held_valid_reg || made;
        result_now      = held_reg;
        if (made)
        begin
            result_now           = '0;
            result_now.data_byte = byte_next;
        end
        if (head_event.eof)
        begin
            if (have_result)
            begin
                held_next       = status;
                held_valid_next = 1'b1;
            end
            else
            begin
                result_now  = status;
                have_result = 1'b1;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = pop && have_result;
            if (pop && have_result)
                out_next = result_now;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            header_reg     <= '0;
            byte_reg       <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                held_valid_reg <= held_valid_next;
                if (head_event.eof)
                begin
                    pos_reg    <= '0;
                    header_reg <= '0;
                    byte_reg   <= '0;
                    cnt_reg    <= '0;
                end
                else
                begin
                    pos_reg    <= pos_next;
                    header_reg <= header_next;
                    byte_reg   <= byte_next;
                    cnt_reg    <= cnt_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (pop)
            held_reg <= held_next;
    end

endmodule

/* hdl/bit_stuffed_frame_deframer_crc8_unit.sv */
// ---------------------------------------------------------------------------
// bit_stuffed_frame_deframer_crc8_unit
// Deframer for bit-stuffed frames with crc-8 check and address decode.
// ---------------------------------------------------------------------------
// Takes one line bit per item, end_of_frame set on the last bit of the
// closing flag, and accepts one item every clock cycle as long as the
// result side keeps up. The first and last eight bits of a frame are the
// flags; stuffed zeros are removed, the remaining bits run through crc-8
// (x^8+x^2+x+1, start value zero), the first two bytes give address and
// control, and i-frame payload comes out as bytes, first bit in the msb.
// Each frame closes with one status item. When the last payload byte and
// the status fall on the same line bit, the status follows with the first
// item of the next frame. An item passes the front stage, an event queue
// of QUEUE_DEPTH entries (two by default) and the back stage; it is
// registered in the queue, then in the output register. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_stuffed_frame_deframer_crc8_unit #(
    parameter int QUEUE_DEPTH = bsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       rx_bit,
    input  logic       end_of_frame,
    // result items
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_status,
    output logic [7:0] data_byte,
    output logic       crc_ok,
    output logic       address_ok,
    output logic       frame_ok,
    output logic [1:0] frame_type,
    output logic [2:0] frame_number,
    output logic       last_frame,
    output logic       too_short
);
    import bsfd_pkg::*;

    cfg_t     cfg_reg;
    logic     push;
    event_t   push_event;
    logic     queue_full;
    logic     pop;
    logic     head_valid;
    event_t   head_event;
    result_t  result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_ADDRESS:      cfg_reg.own_address      <= cfg_data;
                REG_PEER_ADDRESS:     cfg_reg.peer_address     <= cfg_data;
                REG_PEER_ADDRESS_SET: cfg_reg.peer_address_set <= cfg_data[0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // front: flags, destuffing, crc
    bsfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_bit       (rx_bit),
        .end_of_frame (end_of_frame),
        .queue_full   (queue_full),
        .push         (push),
        .push_event   (push_event)
    );

    // event queue
    bsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_event (head_event)
    );

    // back: header, bytes, status
    bsfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_event (head_event),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (result)
    );

    // result fields
    assign is_status    = result.is_status;
    assign data_byte    = result.data_byte;
    assign crc_ok       = result.crc_ok;
    assign address_ok   = result.address_ok;
    assign frame_ok     = result.frame_ok;
    assign frame_type   = result.frame_type;
    assign frame_number = result.frame_number;
    assign last_frame   = result.last_frame;
    assign too_short    = result.too_short;

endmodule
